@@ hdl/kwtm_pkg.sv @@
`timescale 1ns / 1ps

package kwtm_pkg;

    // Slot index and live-count widths cover the full MAX_SOURCES range (2..64)
    localparam int IDX_W = 6;
    localparam int CNT_W = 7;
    localparam int TS_W  = 64;
    localparam int SID_W = 4;
    localparam int MASK_W = 16;

    typedef enum logic [2:0] {
        FUNC_FILL = 3'd0,
        FUNC_END  = 3'd1,
        FUNC_TAKE = 3'd2,
        FUNC_SEEK = 3'd3,
        FUNC_FAIL = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_END       = 2'd1,
        ST_NOT_READY = 2'd2,
        ST_ERROR     = 2'd3
    } status_t;

    // Token that walks the cell row during a take or a seek
    typedef struct packed {
        logic             vld;
        logic             seek;
        logic             found;
        logic [TS_W-1:0]  ts;
        logic [TS_W-1:0]  handle;
        logic [TS_W-1:0]  mark;
        logic [IDX_W-1:0] idx;
    } tok_t;

    // Broadcast command from the controller to every cell
    typedef struct packed {
        logic             fill_en;
        logic             end_en;
        logic             clr_en;
        logic [IDX_W-1:0] sel;
        logic [CNT_W-1:0] live;
        logic [TS_W-1:0]  ts;
        logic [TS_W-1:0]  handle;
        logic [TS_W-1:0]  mark;
    } cmd_t;

endpackage

@@ hdl/kwtm_cell.sv @@
`timescale 1ns / 1ps

module kwtm_cell
    import kwtm_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic clk,
    input  logic rst_n,
    input  cmd_t cmd,
    input  tok_t tok_in,
    output tok_t tok_out,
    output logic pend,
    output logic drop
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);
    localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(IDX);

    logic            valid_reg, valid_next;
    logic            waiting_reg, waiting_next;
    logic            finished_reg, finished_next;
    logic [TS_W-1:0] time_reg;
    logic [TS_W-1:0] handle_reg;
    logic [TS_W-1:0] mark_reg;
    logic            drop_reg;
    tok_t            tok_reg, tok_next;

    logic active;
    logic hit;
    logic older;
    logic take_win;
    logic seek_drop;

    assign active    = MY_CNT < cmd.live;
    assign hit       = cmd.sel == MY_IDX;
    assign older     = $signed(time_reg) < $signed(tok_in.ts);
    assign take_win  = tok_in.vld && !tok_in.seek && active && valid_reg
                       && (!tok_in.found || older);
    assign seek_drop = tok_in.vld && tok_in.seek && active && valid_reg && older;

    always_comb
    begin
        tok_next = tok_in;
        if (take_win)
        begin
            tok_next.found  = 1'b1;
            tok_next.ts     = time_reg;
            tok_next.handle = handle_reg;
            tok_next.mark   = mark_reg;
            tok_next.idx    = MY_IDX;
        end
    end

    always_comb
    begin
        valid_next    = valid_reg;
        waiting_next  = waiting_reg;
        finished_next = finished_reg;
        priority if (cmd.fill_en && hit)
        begin
            valid_next   = 1'b1;
            waiting_next = 1'b0;
        end
        else if (cmd.end_en && hit)
        begin
            finished_next = 1'b1;
            waiting_next  = 1'b0;
        end
        else if ((cmd.clr_en && hit) || seek_drop)
        begin
            // give up the head and wait for the next record
            valid_next   = 1'b0;
            waiting_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            waiting_reg  <= 1'b1;
            finished_reg <= 1'b0;
            tok_reg      <= '0;
        end
        else
        begin
            valid_reg    <= valid_next;
            waiting_reg  <= waiting_next;
            finished_reg <= finished_next;
            tok_reg      <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fill_en && hit)
        begin
            time_reg   <= cmd.ts;
            handle_reg <= cmd.handle;
            mark_reg   <= cmd.mark;
        end
        if (tok_in.vld && tok_in.seek)
        begin
            drop_reg <= seek_drop;
        end
    end

    assign tok_out = tok_reg;
    assign pend    = waiting_reg && !finished_reg && active;
    assign drop    = drop_reg;

endmodule

@@ hdl/k_way_timestamp_merge.sv @@
`timescale 1ns / 1ps
// K-way timestamp merge over MAX_SOURCES head slots.
// Command channel: present func, source_id, time_value, record_handle and
// record_watermark with start; the transaction is taken at a clock edge where
// start is high and busy is low. Each transaction yields exactly one result:
// done is high for one cycle with status, out_time, out_handle, out_seq_mark,
// refill_source and reseek_mask. The receiver cannot stall; sample on done.
// Fill, ended, failed, unknown codes, and a take or seek that finds a slot
// still awaiting its refill: result in the cycle after acceptance, next command
// may follow in the next cycle.
// Take and seek: a token walks the row of slot cells, one cell per cycle, and is
// registered in each cell; busy stays high from acceptance until the token leaves
// the last cell, and no new command is taken until then.
// Configuration: cfg_wr_en writes active_sources from cfg_wr_data; write only
// while idle. Reset: all heads empty, every slot awaiting its first fill, no
// failure, active_sources = 16.
module k_way_timestamp_merge
    import kwtm_pkg::*;
#(
    parameter int MAX_SOURCES = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [2:0]          func,
    input  logic [SID_W-1:0]    source_id,
    input  logic signed [63:0]  time_value,
    input  logic [63:0]         record_handle,
    input  logic [63:0]         record_watermark,
    input  logic                cfg_wr_en,
    input  logic [4:0]          cfg_wr_data,
    output logic                done,
    output logic [1:0]          status,
    output logic signed [63:0]  out_time,
    output logic [63:0]         out_handle,
    output logic [63:0]         out_seq_mark,
    output logic [SID_W-1:0]    refill_source,
    output logic [MASK_W-1:0]   reseek_mask
);

    logic [4:0]              active_sources_reg;
    logic                    failed_reg, failed_next;
    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    status_t                 status_reg, status_next;
    logic [TS_W-1:0]         time_reg, time_next;
    logic [TS_W-1:0]         handle_reg, handle_next;
    logic [TS_W-1:0]         mark_reg, mark_next;
    logic [SID_W-1:0]        refill_reg, refill_next;
    logic [MASK_W-1:0]       mask_reg, mask_next;

    tok_t                    tok_chain [MAX_SOURCES+1];
    tok_t                    tail;
    cmd_t                    cmd;
    logic [MAX_SOURCES-1:0]  pend_vec;
    logic [MAX_SOURCES-1:0]  drop_vec;
    logic [MASK_W-1:0]       drop_mask;
    logic [CNT_W-1:0]        live;
    logic                    accept;
    logic                    any_wait;
    logic                    fill_ok;
    logic                    sid_live;
    func_t                   fn;

    assign accept   = start && !busy_reg;
    assign fn       = func_t'(func);
    assign any_wait = |pend_vec;
    assign tail     = tok_chain[MAX_SOURCES];

    // clamp the configured count to the number of cells
    assign live = (CNT_W'(active_sources_reg) > CNT_W'(MAX_SOURCES))
                  ? CNT_W'(MAX_SOURCES) : CNT_W'(active_sources_reg);
    assign sid_live = CNT_W'(source_id) < live;

    always_comb
    begin
        fill_ok = 1'b0;
        for (int i = 0; i < MAX_SOURCES; i++)
        begin
            if (IDX_W'(i) == IDX_W'(source_id))
            begin
                fill_ok = fill_ok | pend_vec[i];
            end
        end
    end

    // launch a token into the first cell for a take or a seek
    always_comb
    begin
        tok_chain[0].vld    = accept && !failed_reg && !any_wait
                              && (fn == FUNC_TAKE || fn == FUNC_SEEK);
        tok_chain[0].seek   = fn == FUNC_SEEK;
        tok_chain[0].found  = 1'b0;
        tok_chain[0].ts     = time_value;
        tok_chain[0].handle = '0;
        tok_chain[0].mark   = '0;
        tok_chain[0].idx    = '0;
    end

    // broadcast: slot writes on acceptance, winner release at the end of a take
    always_comb
    begin
        cmd.fill_en = accept && !failed_reg && fn == FUNC_FILL && sid_live && fill_ok;
        cmd.end_en  = accept && !failed_reg && fn == FUNC_END && sid_live;
        cmd.clr_en  = tail.vld && !tail.seek && tail.found;
        cmd.sel     = tail.vld ? tail.idx : IDX_W'(source_id);
        cmd.live    = live;
        cmd.ts      = time_value;
        cmd.handle  = record_handle;
        cmd.mark    = record_watermark;
    end

    genvar g;
    generate
        for (g = 0; g < MAX_SOURCES; g++)
        begin : g_cell
            kwtm_cell #(
                .IDX (g)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .cmd     (cmd),
                .tok_in  (tok_chain[g]),
                .tok_out (tok_chain[g+1]),
                .pend    (pend_vec[g]),
                .drop    (drop_vec[g])
            );
        end
        for (g = 0; g < MASK_W; g++)
        begin : g_mask
            if (g < MAX_SOURCES)
            begin : g_live
                assign drop_mask[g] = drop_vec[g];
            end
            else
            begin : g_none
                assign drop_mask[g] = 1'b0;
            end
        end
    endgenerate

    always_comb
    begin
        failed_next = failed_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        status_next = ST_OK;
        time_next   = '0;
        handle_next = '0;
        mark_next   = '0;
        refill_next = '0;
        mask_next   = '0;
        if (tail.vld)
        begin
            // token leaves the last cell: finish the take or seek
            busy_next = 1'b0;
            done_next = 1'b1;
            if (tail.seek)
            begin
                mask_next = drop_mask;
            end
            else if (tail.found)
            begin
                time_next   = tail.ts;
                handle_next = tail.handle;
                mark_next   = tail.mark;
                refill_next = tail.idx[SID_W-1:0];
            end
            else
            begin
                status_next = ST_END;
            end
        end
        else if (accept)
        begin
            done_next = 1'b1;
            if (failed_reg)
            begin
                status_next = ST_ERROR;
            end
            else
            begin
                unique case (fn)
                    FUNC_FILL:
                    begin
                        if (!(sid_live && fill_ok))
                        begin
                            status_next = ST_ERROR;
                        end
                    end
                    FUNC_END:
                    begin
                        status_next = ST_OK;
                    end
                    FUNC_TAKE, FUNC_SEEK:
                    begin
                        if (any_wait)
                        begin
                            status_next = ST_NOT_READY;
                        end
                        else
                        begin
                            // hold the result until the token returns
                            done_next = 1'b0;
                            busy_next = 1'b1;
                        end
                    end
                    FUNC_FAIL:
                    begin
                        failed_next = 1'b1;
                        status_next = ST_ERROR;
                    end
                    default:
                    begin
                        status_next = ST_ERROR;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_sources_reg <= 5'd16;
            failed_reg         <= 1'b0;
            busy_reg           <= 1'b0;
            done_reg           <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                active_sources_reg <= cfg_wr_data;
            end
            failed_reg <= failed_next;
            busy_reg   <= busy_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        time_reg   <= time_next;
        handle_reg <= handle_next;
        mark_reg   <= mark_next;
        refill_reg <= refill_next;
        mask_reg   <= mask_next;
    end

    assign busy          = busy_reg;
    assign done          = done_reg;
    assign status        = status_reg;
    assign out_time      = time_reg;
    assign out_handle    = handle_reg;
    assign out_seq_mark  = mark_reg;
    assign refill_source = refill_reg;
    assign reseek_mask   = mask_reg;

endmodule
